FILE: design/knmr_pkg.sv
// Package of shared constants, types and helper functions for the K-of-M reliability block.
`default_nettype none
package knmr_pkg;

   localparam int NUM_PROB_FIELDS      = 8;
   localparam int DEF_MAX_UNITS        = 8;
   localparam int DEF_MAX_CHAIN_STATES = 16;

   localparam int PROB_W     = 17;
   localparam int RATE_W     = 32;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int WEIGHT_W   = 64;
   localparam int FACTOR_W   = 36;

   localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COUNT      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOTE_THRESHOLD   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_STATE        = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPAIR_CREWS     = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_ONLY_MODE = 8'd4;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_ZERO_DIV = 1'b1;

   typedef struct packed {
      logic                start;
      logic                cap32;
      logic [WEIGHT_W-1:0] x;
      logic [FACTOR_W-1:0] y;
      logic [WEIGHT_W-1:0] den;
   } muldiv_req_type;

   typedef struct packed {
      logic                done;
      logic [WEIGHT_W-1:0] q;
   } muldiv_rsp_type;

   function automatic logic [WEIGHT_W-1:0] sat_add(input logic [WEIGHT_W-1:0] x,
                                                   input logic [WEIGHT_W-1:0] y);
      logic [WEIGHT_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[WEIGHT_W] ? {WEIGHT_W{1'b1}} : s[WEIGHT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: design/knmr_if.sv
// Channel interfaces of the reliability block: request, response and register write.
`default_nettype none
interface knmr_req_if;
   import knmr_pkg::*;
   logic              valid;
   logic              ready;
   logic [PROB_W-1:0] prob_unit0;
   logic [PROB_W-1:0] prob_unit1;
   logic [PROB_W-1:0] prob_unit2;
   logic [PROB_W-1:0] prob_unit3;
   logic [PROB_W-1:0] prob_unit4;
   logic [PROB_W-1:0] prob_unit5;
   logic [PROB_W-1:0] prob_unit6;
   logic [PROB_W-1:0] prob_unit7;
   logic [RATE_W-1:0] fail_rate;
   logic [RATE_W-1:0] repair_rate;
   modport source(output valid, prob_unit0, prob_unit1, prob_unit2, prob_unit3, prob_unit4,
                  prob_unit5, prob_unit6, prob_unit7, fail_rate, repair_rate, input ready);
   modport sink(input valid, prob_unit0, prob_unit1, prob_unit2, prob_unit3, prob_unit4,
                prob_unit5, prob_unit6, prob_unit7, fail_rate, repair_rate, output ready);
endinterface

interface knmr_rsp_if;
   import knmr_pkg::*;
   logic              valid;
   logic              ready;
   logic [PROB_W-1:0] system_prob;
   logic [RATE_W-1:0] system_fail_rate;
   logic [RATE_W-1:0] system_repair_rate;
   logic              status_code;
   modport source(output valid, system_prob, system_fail_rate, system_repair_rate,
                  status_code, input ready);
   modport sink(input valid, system_prob, system_fail_rate, system_repair_rate,
                status_code, output ready);
endinterface

interface knmr_csr_if;
   import knmr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/k_of_n_markov_reliability.sv
// Top level of the K-of-M reliability block with birth-death repair chain rates.
//
//   channel   direction  transfer when         carries
//   req_chan  in         valid && ready        unit probabilities, fail and repair rate
//   rsp_chan  out        valid && ready        system probability, two rates, status
//   csr_chan  in         valid (ready is 1)    register index and write data
//
// An item runs the probability sum over 2^M pattern slots, where a counted pattern folds
// one factor per unit through the pattern multiplier and a skipped one is passed over, then
// the shared multiply-divide unit for each of the I chain steps and for each of the two rates.
// Reset is synchronous and active high; it restores the register defaults and empties the
// result register. The request side is not ready while an item is being worked on; a
// finished result waits in the output register and the next request may then be taken.
`default_nettype none
module k_of_n_markov_reliability #(
   parameter int MAX_UNITS        = knmr_pkg::DEF_MAX_UNITS,
   parameter int MAX_CHAIN_STATES = knmr_pkg::DEF_MAX_CHAIN_STATES
) (
   input  logic       clock,
   input  logic       reset,
   knmr_req_if.sink   req_chan,
   knmr_rsp_if.source rsp_chan,
   knmr_csr_if.sink   csr_chan
);
   import knmr_pkg::*;

   localparam int PAT_W  = MAX_UNITS + 1;
   localparam int UNIT_W = $clog2(MAX_UNITS);
   localparam int PRD_W  = 33;
   localparam int SUM_W  = PRD_W + MAX_UNITS;
   localparam int IDX_W  = CFG_W + 1;

   // Sequencer states, one hot.
   typedef enum logic [9:0] {
      ST_IDLE        = 10'b0000000001,
      ST_PSUM        = 10'b0000000010,
      ST_PROUND      = 10'b0000000100,
      ST_CHAIN_ISSUE = 10'b0000001000,
      ST_CHAIN_WAIT  = 10'b0000010000,
      ST_FR_ISSUE    = 10'b0000100000,
      ST_FR_WAIT     = 10'b0001000000,
      ST_RR_ISSUE    = 10'b0010000000,
      ST_RR_WAIT     = 10'b0100000000,
      ST_OUT         = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CFG_W-1:0] input_count_ff, vote_threshold_ff, top_state_ff, repair_crews_ff;
   logic             active_only_mode_ff;

   // Item operands.
   logic [PROB_W-1:0] prob_ff [MAX_UNITS];
   logic [PROB_W-1:0] prob_in [MAX_UNITS];
   logic [PROB_W-1:0] req_prob [NUM_PROB_FIELDS];
   logic [RATE_W-1:0] lambda_ff, lambda_in, mu_ff, mu_in;

   // Probability sum loop.
   logic [PAT_W-1:0]  pat_ff, pat_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic [PRD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]  psum_ff, psum_in;
   logic [PROB_W-1:0] sysprob_ff, sysprob_in;

   // Chain loop.
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [WEIGHT_W-1:0] p_prev_ff, p_prev_in, sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic [WEIGHT_W-1:0] p_d_ff, p_d_in, p_d1_ff, p_d1_in;
   logic [FACTOR_W-1:0] a_d1_ff, a_d1_in, b_d1_ff, b_d1_in;
   logic [RATE_W-1:0]   fr_ff, fr_in, rr_ff, rr_in;
   logic                status_ff, status_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0] out_prob_ff, out_prob_in;
   logic [RATE_W-1:0] out_fr_ff, out_fr_in, out_rr_ff, out_rr_in;
   logic              out_status_ff, out_status_in;

   muldiv_req_type md_req;
   muldiv_rsp_type md_rsp;

   logic                 req_fire, out_free;
   logic [CFG_W-1:0]     m_eff, k_val, top_eff, d_val;
   logic                 chain_ok;
   logic [PAT_W-1:0]     pat_end;
   logic                 pat_skip;
   logic [PROB_W-1:0]    unit_prob, factor;
   logic [PRD_W+PROB_W-1:0] prod_mul;
   logic [PRD_W-1:0]     prod_next;
   logic [SUM_W-1:0]     psum_round;
   logic signed [6:0]    c_val;
   logic [CFG_W-1:0]     fail_cnt, crew_cnt;
   logic [FACTOR_W-1:0]  a_cur, b_cur;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Register writes; unknown indexes are dropped.
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         input_count_ff      <= CFG_W'(3);
         vote_threshold_ff   <= CFG_W'(1);
         top_state_ff        <= CFG_W'(3);
         repair_crews_ff     <= CFG_W'(1);
         active_only_mode_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_INPUT_COUNT:      input_count_ff      <= csr_chan.data[CFG_W-1:0];
            REG_VOTE_THRESHOLD:   vote_threshold_ff   <= csr_chan.data[CFG_W-1:0];
            REG_TOP_STATE:        top_state_ff        <= csr_chan.data[CFG_W-1:0];
            REG_REPAIR_CREWS:     repair_crews_ff     <= csr_chan.data[CFG_W-1:0];
            REG_ACTIVE_ONLY_MODE: active_only_mode_ff <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // Effective chain configuration: the unit count is clamped to one and MAX_UNITS, and
   // the top state to the chain depth.
   always_comb begin
      if (input_count_ff == '0) begin
         m_eff = CFG_W'(1);
      end else if (int'(input_count_ff) > MAX_UNITS) begin
         m_eff = CFG_W'(MAX_UNITS);
      end else begin
         m_eff = input_count_ff;
      end
      if (int'(top_state_ff) > MAX_CHAIN_STATES - 1) begin
         top_eff = CFG_W'(MAX_CHAIN_STATES - 1);
      end else begin
         top_eff = top_state_ff;
      end
      k_val    = vote_threshold_ff;
      d_val    = m_eff - k_val;
      chain_ok = (k_val != '0) && (k_val <= m_eff) && (d_val <= top_eff) &&
                 (repair_crews_ff != '0) && (mu_ff != '0) && (top_eff != '0);
   end

   // Request payload gathered into an array; probabilities above one are clipped.
   assign req_prob[0] = req_chan.prob_unit0;
   assign req_prob[1] = req_chan.prob_unit1;
   assign req_prob[2] = req_chan.prob_unit2;
   assign req_prob[3] = req_chan.prob_unit3;
   assign req_prob[4] = req_chan.prob_unit4;
   assign req_prob[5] = req_chan.prob_unit5;
   assign req_prob[6] = req_chan.prob_unit6;
   assign req_prob[7] = req_chan.prob_unit7;

   always_comb begin
      for (int j = 0; j < MAX_UNITS; j++) begin
         if (req_fire) begin
            prob_in[j] = (req_prob[j] > ONE_Q16) ? ONE_Q16 : req_prob[j];
         end else begin
            prob_in[j] = prob_ff[j];
         end
      end
   end

   // Pattern datapath: one factor per cycle folded into the running Q1.32 product.
   assign pat_end   = PAT_W'(1) << m_eff;
   assign pat_skip  = (unit_ff == '0) && ($countones(pat_ff[MAX_UNITS-1:0]) < int'(k_val));
   assign unit_prob = prob_ff[unit_ff];
   assign factor    = pat_ff[unit_ff] ? unit_prob : (ONE_Q16 - unit_prob);
   assign prod_mul  = (PRD_W+PROB_W)'(prod_ff) * (PRD_W+PROB_W)'(factor);
   assign prod_next = prod_mul[PRD_W+15:16];
   assign psum_round = (psum_ff + SUM_W'(32768)) >> 16;

   // Chain coefficients of step i: failure count times lambda and crew count times mu.
   always_comb begin
      c_val = $signed({3'b0, m_eff}) - $signed({2'b0, i_ff}) + 7'sd1;
      if (!active_only_mode_ff || (c_val < $signed({3'b0, k_val}))) begin
         fail_cnt = (c_val < 7'sd0) ? '0 : c_val[CFG_W-1:0];
      end else begin
         fail_cnt = k_val;
      end
      crew_cnt = (i_ff <= {1'b0, repair_crews_ff}) ? i_ff[CFG_W-1:0] : repair_crews_ff;
      a_cur    = FACTOR_W'(fail_cnt) * FACTOR_W'(lambda_ff);
      b_cur    = FACTOR_W'(crew_cnt) * FACTOR_W'(mu_ff);
   end

   // Operands of the shared multiply-divide unit.
   always_comb begin
      md_req.start = (state_ff == ST_CHAIN_ISSUE) || (state_ff == ST_FR_ISSUE) ||
                     (state_ff == ST_RR_ISSUE);
      md_req.cap32 = (state_ff != ST_CHAIN_ISSUE);
      md_req.x     = p_prev_ff;
      md_req.y     = a_cur;
      md_req.den   = WEIGHT_W'(b_cur);
      if (state_ff == ST_FR_ISSUE) begin
         md_req.x   = p_d_ff;
         md_req.y   = a_d1_ff;
         md_req.den = sum1_ff;
      end else if (state_ff == ST_RR_ISSUE) begin
         md_req.x   = p_d1_ff;
         md_req.y   = b_d1_ff;
         md_req.den = sum2_ff;
      end
   end

   knmr_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      lambda_in     = lambda_ff;
      mu_in         = mu_ff;
      pat_in        = pat_ff;
      unit_in       = unit_ff;
      prod_in       = prod_ff;
      psum_in       = psum_ff;
      sysprob_in    = sysprob_ff;
      i_in          = i_ff;
      p_prev_in     = p_prev_ff;
      sum1_in       = sum1_ff;
      sum2_in       = sum2_ff;
      p_d_in        = p_d_ff;
      p_d1_in       = p_d1_ff;
      a_d1_in       = a_d1_ff;
      b_d1_in       = b_d1_ff;
      fr_in         = fr_ff;
      rr_in         = rr_ff;
      status_in     = status_ff;
      out_prob_in   = out_prob_ff;
      out_fr_in     = out_fr_ff;
      out_rr_in     = out_rr_ff;
      out_status_in = out_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               lambda_in = req_chan.fail_rate;
               mu_in     = req_chan.repair_rate;
               pat_in    = '0;
               unit_in   = '0;
               prod_in   = PRD_W'(1) << 32;
               psum_in   = '0;
               i_in      = IDX_W'(1);
               p_prev_in = WEIGHT_W'(1) << 32;
               sum1_in   = WEIGHT_W'(1) << 32;
               sum2_in   = '0;
               fr_in     = {RATE_W{1'b1}};
               rr_in     = {RATE_W{1'b1}};
               status_in = STATUS_ZERO_DIV;
               state_in  = ST_PSUM;
            end
         end
         ST_PSUM: begin
            if (pat_ff == pat_end) begin
               state_in = ST_PROUND;
            end else if (pat_skip) begin
               pat_in = pat_ff + 1'b1;
            end else if (unit_ff == UNIT_W'(m_eff - 1'b1)) begin
               psum_in = psum_ff + SUM_W'(prod_next);
               pat_in  = pat_ff + 1'b1;
               unit_in = '0;
               prod_in = PRD_W'(1) << 32;
            end else begin
               prod_in = prod_next;
               unit_in = unit_ff + 1'b1;
            end
         end
         ST_PROUND: begin
            sysprob_in = (psum_round > SUM_W'(ONE_Q16)) ? ONE_Q16 : psum_round[PROB_W-1:0];
            state_in   = chain_ok ? ST_CHAIN_ISSUE : ST_OUT;
         end
         ST_CHAIN_ISSUE: begin
            // Step d+1 supplies the weight at the boundary and both of its coefficients.
            if (i_ff == IDX_W'(d_val) + 1'b1) begin
               p_d_in  = p_prev_ff;
               a_d1_in = a_cur;
               b_d1_in = b_cur;
            end
            state_in = ST_CHAIN_WAIT;
         end
         ST_CHAIN_WAIT: begin
            if (md_rsp.done) begin
               p_prev_in = md_rsp.q;
               if (i_ff <= IDX_W'(d_val)) begin
                  sum1_in = sat_add(sum1_ff, md_rsp.q);
               end else begin
                  sum2_in = sat_add(sum2_ff, md_rsp.q);
               end
               if (i_ff == IDX_W'(d_val) + 1'b1) begin
                  p_d1_in = md_rsp.q;
               end
               if (i_ff == IDX_W'(top_eff)) begin
                  // The down-state sum is checked with this step's weight included when it is a down state.
                  if ((i_ff > IDX_W'(d_val)) ? (sat_add(sum2_ff, md_rsp.q) == '0)
                                             : (sum2_ff == '0)) begin
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_FR_ISSUE;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_CHAIN_ISSUE;
               end
            end
         end
         ST_FR_ISSUE: begin
            state_in = ST_FR_WAIT;
         end
         ST_FR_WAIT: begin
            if (md_rsp.done) begin
               fr_in    = md_rsp.q[RATE_W-1:0];
               state_in = ST_RR_ISSUE;
            end
         end
         ST_RR_ISSUE: begin
            state_in = ST_RR_WAIT;
         end
         ST_RR_WAIT: begin
            if (md_rsp.done) begin
               rr_in     = md_rsp.q[RATE_W-1:0];
               status_in = STATUS_OK;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_prob_in   = sysprob_ff;
               out_fr_in     = fr_ff;
               out_rr_in     = rr_ff;
               out_status_in = status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prob_ff       <= prob_in;
      lambda_ff     <= lambda_in;
      mu_ff         <= mu_in;
      pat_ff        <= pat_in;
      unit_ff       <= unit_in;
      prod_ff       <= prod_in;
      psum_ff       <= psum_in;
      sysprob_ff    <= sysprob_in;
      i_ff          <= i_in;
      p_prev_ff     <= p_prev_in;
      sum1_ff       <= sum1_in;
      sum2_ff       <= sum2_in;
      p_d_ff        <= p_d_in;
      p_d1_ff       <= p_d1_in;
      a_d1_ff       <= a_d1_in;
      b_d1_ff       <= b_d1_in;
      fr_ff         <= fr_in;
      rr_ff         <= rr_in;
      status_ff     <= status_in;
      out_prob_ff   <= out_prob_in;
      out_fr_ff     <= out_fr_in;
      out_rr_ff     <= out_rr_in;
      out_status_ff <= out_status_in;
   end

   assign req_chan.ready              = (state_ff == ST_IDLE);
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.system_prob        = out_prob_ff;
   assign rsp_chan.system_fail_rate   = out_fr_ff;
   assign rsp_chan.system_repair_rate = out_rr_ff;
   assign rsp_chan.status_code        = out_status_ff;

`ifndef NO_ASSERTIONS
   // A taken request closes the request side until the item is finished.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request side still ready after a transfer");

   // A result with the error status always carries saturated values on both rates.
   a_status_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status_code == STATUS_ZERO_DIV)) |->
      ((rsp_chan.system_fail_rate == {RATE_W{1'b1}}) &&
       (rsp_chan.system_repair_rate == {RATE_W{1'b1}})))
      else $error("error status without saturated rates");

   // The system probability never exceeds one.
   a_prob_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.system_prob <= ONE_Q16))
      else $error("system probability above one");

   // The shared unit is only started from the divide issue states.
   a_md_start_states: assert property (@(posedge clock) disable iff (reset)
      md_req.start |-> !req_chan.ready && (state_ff != ST_PSUM) && (state_ff != ST_OUT))
      else $error("divide unit started outside the chain or rate phase");
`endif

endmodule
`default_nettype wire

FILE: design/knmr_muldiv.sv
// Iterative multiply then restoring divide unit with saturation, one quotient bit per cycle.
`default_nettype none
module knmr_muldiv (
   input  logic                     clock,
   input  logic                     reset,
   input  knmr_pkg::muldiv_req_type md_req,
   output knmr_pkg::muldiv_rsp_type md_rsp
);
   import knmr_pkg::*;

   localparam int PROD_W = WEIGHT_W + FACTOR_W;
   localparam int PP_W   = 32 + FACTOR_W;
   localparam int CNT_W  = $clog2(WEIGHT_W);

   typedef enum logic [4:0] {
      MD_IDLE   = 5'b00001,
      MD_MUL_LO = 5'b00010,
      MD_MUL_HI = 5'b00100,
      MD_CHECK  = 5'b01000,
      MD_DIV    = 5'b10000
   } md_state_type;

   md_state_type        state_ff, state_in;
   logic [WEIGHT_W-1:0] x_ff, x_in;
   logic [FACTOR_W-1:0] y_ff, y_in;
   logic [WEIGHT_W-1:0] den_ff, den_in;
   logic                cap32_ff, cap32_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [WEIGHT_W-1:0] rem_ff, rem_in;
   logic [WEIGHT_W-1:0] lo_ff, lo_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [WEIGHT_W-1:0] result_ff, result_in;

   logic [31:0]         mul_a;
   logic [PP_W-1:0]     pp;
   logic [WEIGHT_W:0]   shifted, diff;
   logic                ge;
   logic [WEIGHT_W-1:0] cap;
   logic [WEIGHT_W-1:0] q_next;

   assign mul_a   = (state_ff == MD_MUL_LO) ? x_ff[31:0] : x_ff[63:32];
   assign pp      = PP_W'(mul_a) * PP_W'(y_ff);
   assign shifted = {rem_ff, lo_ff[WEIGHT_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};
   assign cap     = cap32_ff ? {32'b0, 32'hFFFF_FFFF} : {WEIGHT_W{1'b1}};
   assign q_next  = {q_ff[WEIGHT_W-2:0], ge};

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      den_in    = den_ff;
      cap32_in  = cap32_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      lo_in     = lo_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               x_in     = md_req.x;
               y_in     = md_req.y;
               den_in   = md_req.den;
               cap32_in = md_req.cap32;
               state_in = MD_MUL_LO;
            end
         end
         MD_MUL_LO: begin
            prod_in  = PROD_W'(pp);
            state_in = MD_MUL_HI;
         end
         MD_MUL_HI: begin
            prod_in  = prod_ff + {pp, 32'b0};
            state_in = MD_CHECK;
         end
         MD_CHECK: begin
            if (WEIGHT_W'(prod_ff[PROD_W-1:WEIGHT_W]) >= den_ff) begin
               result_in = cap;
               done_in   = 1'b1;
               state_in  = MD_IDLE;
            end else begin
               rem_in   = WEIGHT_W'(prod_ff[PROD_W-1:WEIGHT_W]);
               lo_in    = prod_ff[WEIGHT_W-1:0];
               q_in     = '0;
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            rem_in = ge ? diff[WEIGHT_W-1:0] : shifted[WEIGHT_W-1:0];
            lo_in  = {lo_ff[WEIGHT_W-2:0], 1'b0};
            q_in   = q_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WEIGHT_W - 1)) begin
               result_in = (q_next > cap) ? cap : q_next;
               done_in   = 1'b1;
               state_in  = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      den_ff    <= den_in;
      cap32_ff  <= cap32_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      lo_ff     <= lo_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q    = result_ff;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the K-of-M reliability block with repair chain rates.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import knmr_pkg::*;

   // One request and one response as the testbench sees them.
   typedef struct {
      logic [PROB_W-1:0] prob [0:7];
      logic [RATE_W-1:0] lam;
      logic [RATE_W-1:0] mu;
   } unit_req_type;

   typedef struct {
      logic [PROB_W-1:0] prob;
      logic [RATE_W-1:0] fail;
      logic [RATE_W-1:0] repair;
      logic              status;
   } sys_rsp_type;

   // Row of the directed table. When typed is set, the probability and the status
   // come from the row itself, and a saturated status also fixes both rates.
   typedef struct {
      unit_req_type      item;
      bit                typed;
      logic [PROB_W-1:0] prob_exp;
      logic              status_exp;
   } directed_row_type;

   localparam int          CYCLE_LIMIT = 20_000_000;
   localparam int          TOTAL_ITEMS = 1400;
   localparam int          SETTLE      = 200;
   localparam logic [31:0] RATE_MAX    = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   knmr_req_if req_chan();
   knmr_rsp_if rsp_chan();
   knmr_csr_if csr_chan();

   k_of_n_markov_reliability i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always #10 clock = ~clock;

   // Shadow copy of the registers, updated on every register transfer.
   logic [3:0] units_cfg  = 4'd3;
   logic [3:0] vote_cfg   = 4'd1;
   logic [3:0] top_cfg    = 4'd3;
   logic [3:0] crews_cfg  = 4'd1;
   logic       active_cfg = 1'b0;

   sys_rsp_type pending_rsp [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          items_sent  = 0;
   bit          quiet_phase = 1'b0;

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // (x*y)/den on the full 128-bit product, truncated, and saturated at cap.
   function automatic logic [63:0] scaled_quotient(logic [63:0] x, logic [63:0] y,
                                                   logic [63:0] den, logic [63:0] cap);
      logic [127:0] w;
      logic [127:0] q;
      w = {64'd0, x} * {64'd0, y};
      if (w[127:64] >= den) return cap;
      q = w / {64'd0, den};
      return (q[63:0] > cap) ? cap : q[63:0];
   endfunction

   function automatic logic [63:0] add_clamped(logic [63:0] x, logic [63:0] y);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   // Works out the system probability and the equivalent chain rates for one request
   // under the current shadow registers.
   function automatic sys_rsp_type reliability_of(unit_req_type it);
      sys_rsp_type r;
      int          m, k, top, crews, d, i, j, ones, c, cnt;
      logic [63:0] pv [0:7];
      logic [63:0] a [0:16];
      logic [63:0] b [0:16];
      logic [63:0] p [0:16];
      logic [63:0] total, sum1, sum2, prod, f, lam, mu;
      m     = units_cfg;
      k     = vote_cfg;
      top   = top_cfg;
      crews = crews_cfg;
      lam   = {32'd0, it.lam};
      mu    = {32'd0, it.mu};
      if (m < 1) m = 1;
      if (m > 8) m = 8;
      for (j = 0; j < 8; j++)
         pv[j] = (it.prob[j] > ONE_Q16) ? 64'd65536 : {47'd0, it.prob[j]};

      // Probability that at least K units work, over every success pattern.
      total = 0;
      for (int pat = 0; pat < (1 << m); pat++) begin
         ones = 0;
         for (j = 0; j < m; j++) ones += (pat >> j) & 1;
         if (ones >= k) begin
            prod = 64'd1 << 32;
            for (j = 0; j < m; j++) begin
               f = ((pat >> j) & 1) ? pv[j] : (64'd65536 - pv[j]);
               prod = (prod * f) >> 16;
            end
            total += prod;
         end
      end
      total = (total + 64'd32768) >> 16;
      if (total > 64'd65536) total = 64'd65536;
      r.prob   = total[PROB_W-1:0];
      r.fail   = RATE_MAX;
      r.repair = RATE_MAX;
      r.status = STATUS_ZERO_DIV;

      // Birth-death chain; any undefined shape or zero divisor leaves the rates saturated.
      d = m - k;
      if (k >= 1 && k <= m && d <= top && crews != 0 && mu != 0) begin
         p[0] = 64'd1 << 32;
         for (i = 1; i <= top + 1; i++) begin
            c    = m - i + 1;
            cnt  = (!active_cfg || c < k) ? ((c < 0) ? 0 : c) : k;
            a[i] = cnt * lam;
            b[i] = ((i <= crews) ? i : crews) * mu;
            p[i] = scaled_quotient(p[i-1], a[i], b[i], 64'hFFFF_FFFF_FFFF_FFFF);
         end
         sum1 = 0;
         sum2 = 0;
         for (i = 0; i <= d; i++) sum1 = add_clamped(sum1, p[i]);
         for (i = d + 1; i <= top; i++) sum2 = add_clamped(sum2, p[i]);
         if (sum2 != 0) begin
            prod     = scaled_quotient(p[d], a[d+1], sum1, {32'd0, RATE_MAX});
            r.fail   = prod[31:0];
            prod     = scaled_quotient(p[d+1], b[d+1], sum2, {32'd0, RATE_MAX});
            r.repair = prod[31:0];
            r.status = STATUS_OK;
         end
      end
      return r;
   endfunction

   // Register write; the shadow copy follows the transfer.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(negedge clock); while (!csr_chan.ready);
      @(posedge clock);
      case (idx)
         REG_INPUT_COUNT:      units_cfg  = value[3:0];
         REG_VOTE_THRESHOLD:   vote_cfg   = value[3:0];
         REG_TOP_STATE:        top_cfg    = value[3:0];
         REG_REPAIR_CREWS:     crews_cfg  = value[3:0];
         REG_ACTIVE_ONLY_MODE: active_cfg = value[0];
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(int m, int k, int top, int crews, int mode);
      csr_write(REG_INPUT_COUNT, {4'($urandom_range(0, 15)), 4'(m)});
      csr_write(REG_VOTE_THRESHOLD, 8'(k));
      csr_write(REG_TOP_STATE, 8'(top));
      csr_write(REG_REPAIR_CREWS, 8'(crews));
      csr_write(REG_ACTIVE_ONLY_MODE, {7'($urandom_range(0, 127)), 1'(mode)});
   endtask

   // Registers change only with the block idle: every result back, then a pause
   // long enough for anything still in flight to settle.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Sends one request; the expectation is recorded at the transfer. The valid stays
   // high across back-to-back transfers and is only lowered ahead of a gap.
   task automatic send_request(unit_req_type it, bit typed, logic [PROB_W-1:0] prob_exp,
                               logic status_exp);
      int          gap;
      sys_rsp_type want;
      gap = gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.prob_unit0  <= it.prob[0];
      req_chan.prob_unit1  <= it.prob[1];
      req_chan.prob_unit2  <= it.prob[2];
      req_chan.prob_unit3  <= it.prob[3];
      req_chan.prob_unit4  <= it.prob[4];
      req_chan.prob_unit5  <= it.prob[5];
      req_chan.prob_unit6  <= it.prob[6];
      req_chan.prob_unit7  <= it.prob[7];
      req_chan.fail_rate   <= it.lam;
      req_chan.repair_rate <= it.mu;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      want = reliability_of(it);
      if (typed) begin
         want.prob   = prob_exp;
         want.status = status_exp;
         if (status_exp == STATUS_ZERO_DIV) begin
            want.fail   = RATE_MAX;
            want.repair = RATE_MAX;
         end
      end
      pending_rsp = {pending_rsp, want};
      items_sent++;
   endtask

   function automatic unit_req_type random_request();
      unit_req_type it;
      int           r;
      for (int j = 0; j < 8; j++) begin
         r = $urandom_range(0, 99);
         if (r < 80)      it.prob[j] = 17'($urandom_range(0, 65536));
         else if (r < 88) it.prob[j] = (r & 1) ? ONE_Q16 : 17'd0;
         else             it.prob[j] = 17'($urandom_range(0, 17'h1FFFF));
      end
      for (int n = 0; n < 2; n++) begin
         logic [31:0] v;
         r = $urandom_range(0, 99);
         if (r < 25)      v = $urandom;
         else if (r < 45) v = $urandom_range(0, 3);
         else if (r < 52) v = 32'd0;
         else             v = $urandom_range(1, 32'h00FF_FFFF);
         if (n == 0) it.lam = v;
         else        it.mu  = v;
      end
      return it;
   endfunction

   function automatic unit_req_type flat_request(logic [PROB_W-1:0] pr, logic [31:0] lam,
                                                 logic [31:0] mu);
      unit_req_type it;
      for (int j = 0; j < 8; j++) it.prob[j] = pr;
      it.lam = lam;
      it.mu  = mu;
      return it;
   endfunction

   // Response side: the handshake and the payload are sampled at the falling edge,
   // where nothing moves, and the transfer is checked at the next rising edge.
   logic        rsp_fire;
   sys_rsp_type rsp_seen;

   always @(negedge clock) begin
      rsp_fire        <= rsp_chan.valid && rsp_chan.ready && !reset;
      rsp_seen.prob   <= rsp_chan.system_prob;
      rsp_seen.fail   <= rsp_chan.system_fail_rate;
      rsp_seen.repair <= rsp_chan.system_repair_rate;
      rsp_seen.status <= rsp_chan.status_code;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_fire === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response transfer with nothing expected, actual prob %0d",
                     $time, rsp_seen.prob);
            error_count++;
         end else begin
            sys_rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_seen.prob !== want.prob) begin
               $display("%0t: system_prob expected %0d actual %0d", $time, want.prob,
                        rsp_seen.prob);
               error_count++;
            end
            if (rsp_seen.fail !== want.fail) begin
               $display("%0t: system_fail_rate expected %h actual %h", $time, want.fail,
                        rsp_seen.fail);
               error_count++;
            end
            if (rsp_seen.repair !== want.repair) begin
               $display("%0t: system_repair_rate expected %h actual %h", $time, want.repair,
                        rsp_seen.repair);
               error_count++;
            end
            if (rsp_seen.status !== want.status) begin
               $display("%0t: status_code expected %0d actual %0d", $time, want.status,
                        rsp_seen.status);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls in bursts of random length, with quiet phases left open.
   initial begin
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Run limit, reckoned from the slowest correct run and taken several times over.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Main sequence: directed table under reset defaults, a sweep over the corner
   // settings, then random phases with a fresh setting each.
   initial begin
      directed_row_type table_rows [$];
      directed_row_type row;
      int               m, k, phase_items;
      req_chan.valid       <= 1'b0;
      req_chan.prob_unit0  <= '0;
      req_chan.prob_unit1  <= '0;
      req_chan.prob_unit2  <= '0;
      req_chan.prob_unit3  <= '0;
      req_chan.prob_unit4  <= '0;
      req_chan.prob_unit5  <= '0;
      req_chan.prob_unit6  <= '0;
      req_chan.prob_unit7  <= '0;
      req_chan.fail_rate   <= '0;
      req_chan.repair_rate <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= '0;
      csr_chan.data        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With every unit dead, at least one working unit is impossible.
      row = '{flat_request(17'd0, 32'd1, 32'd1), 1'b1, 17'd0, STATUS_OK};
      table_rows = {table_rows, row};
      // Every unit certain to work.
      row = '{flat_request(ONE_Q16, 32'h0001_0000, 32'h0001_0000), 1'b1, ONE_Q16, STATUS_OK};
      table_rows = {table_rows, row};
      // A probability above one counts as one.
      row = '{flat_request(17'h1FFFF, 32'd5, 32'd7), 1'b1, ONE_Q16, STATUS_OK};
      table_rows = {table_rows, row};
      // No repair at all: zero divisor.
      row = '{flat_request(17'd0, 32'h0001_0000, 32'd0), 1'b1, 17'd0, STATUS_ZERO_DIV};
      table_rows = {table_rows, row};
      // No failures: the upper part of the chain is empty.
      row = '{flat_request(ONE_Q16, 32'd0, 32'h0001_0000), 1'b1, ONE_Q16, STATUS_ZERO_DIV};
      table_rows = {table_rows, row};
      // Rate extremes, checked against the predictor.
      row = '{flat_request(17'h08000, RATE_MAX, RATE_MAX), 1'b0, 17'd0, STATUS_OK};
      table_rows = {table_rows, row};
      row = '{flat_request(17'h0FFFF, RATE_MAX, 32'd1), 1'b0, 17'd0, STATUS_OK};
      table_rows = {table_rows, row};
      row = '{flat_request(17'd1, 32'd1, RATE_MAX), 1'b0, 17'd0, STATUS_OK};
      table_rows = {table_rows, row};
      foreach (table_rows[n])
         send_request(table_rows[n].item, table_rows[n].typed, table_rows[n].prob_exp,
                      table_rows[n].status_exp);

      // Corner settings, two requests each: unit count zero and above the maximum,
      // threshold zero and above the unit count, a chain too short for the threshold,
      // no repair crews, the active-only mode, and writes to unknown registers.
      for (int s = 0; s < 8; s++) begin
         wait_for_drain();
         case (s)
            0: load_config(0, 1, 3, 1, 0);
            1: load_config(8, 0, 15, 1, 0);
            2: load_config(2, 5, 3, 1, 0);
            3: load_config(8, 1, 2, 2, 0);
            4: load_config(4, 2, 5, 0, 0);
            5: load_config(8, 3, 15, 15, 1);
            6: load_config(15, 8, 15, 15, 1);
            default: begin
               load_config(1, 1, 1, 1, 1);
               csr_write(8'd5, 8'hFF);
               csr_write(8'hFF, 8'h00);
            end
         endcase
         repeat (2) send_request(random_request(), 1'b0, '0, 1'b0);
      end

      // Random phases. Large unit counts are slow, so most phases keep them small.
      while (items_sent < TOTAL_ITEMS) begin
         wait_for_drain();
         quiet_phase = ($urandom_range(0, 3) == 0);
         m = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 8);
         if ($urandom_range(0, 19) == 0) m = ($urandom_range(0, 1) != 0) ? 0 : 9 + $urandom_range(0, 6);
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, (m > 8) ? 8 : ((m < 1) ? 1 : m));
         load_config(m, k, $urandom_range(0, 15),
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 15),
                     $urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0)
            csr_write(8'($urandom_range(5, 255)), 8'($urandom_range(0, 255)));
         phase_items = $urandom_range(20, 60);
         for (int n = 0; n < phase_items; n++)
            send_request(random_request(), 1'b0, '0, 1'b0);
      end

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: k_of_n_markov_reliability.f
design/knmr_pkg.sv
design/knmr_if.sv
design/knmr_muldiv.sv
design/k_of_n_markov_reliability.sv
sim/testbench.sv
